// ===== design/sbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbl_pkg - shared types, constants and helpers of the 5x5 separable blur
// Pixel and sum types, tap weights, register codes and the divide-by-ten
// used by both the horizontal and the vertical pass.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int TAPS          = 5;
	localparam int LINES         = TAPS - 1;
	localparam int DIM_W         = 12;
	localparam int MIN_DIM       = 5;
	localparam int RESET_WIDTH   = 640;
	localparam int RESET_HEIGHT  = 480;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// 10 * 255 fits in 12 bits
	localparam int SUM_W = 12;
	localparam int WT_W  = 3;
	localparam logic [WT_W-1:0] TAP_WEIGHT [TAPS] = '{3'd1, 3'd2, 3'd4, 3'd2, 3'd1};

	// x / 10 == (x * 6554) >> 16, exact for x below 16384
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP10 = 13'd6554;
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} sum_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       frame_end;
	} res_t;

	// per-tick flags travelling down the pipeline
	typedef struct packed {
		logic make;       // a result leaves for this tick
		logic hc;         // column inside the horizontal window
		logic row_valid;  // tick row belongs to the frame
		logic vblur;      // row inside the vertical window
		logic last;       // last result of the frame
	} ctrl_t;

	typedef struct packed {
		logic [FIFO_AW:0] count;
		logic             not_empty;
	} fifo_stat_t;

	localparam sum_t SUM_ZERO = '0;

	function automatic logic [SUM_W-1:0] wmul(input logic [7:0] v, input logic [WT_W-1:0] wt);
		return SUM_W'(v) * SUM_W'(wt);
	endfunction

	function automatic sum_t sum_add(input sum_t acc, input pix_t p, input logic [WT_W-1:0] wt);
		sum_t r;
		r.red   = acc.red   + wmul(p.red,   wt);
		r.green = acc.green + wmul(p.green, wt);
		r.blue  = acc.blue  + wmul(p.blue,  wt);
		return r;
	endfunction

	function automatic logic [7:0] div10(input logic [SUM_W-1:0] x);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(x) * PROD_W'(RECIP10);
		return prod[23:16];
	endfunction

	function automatic pix_t sum_div10(input sum_t s);
		pix_t r;
		r.red   = div10(s.red);
		r.green = div10(s.green);
		r.blue  = div10(s.blue);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/separable_blur_5x5.sv =====
// ----------------------------------------------------------------------------
// separable_blur_5x5 - 5x5 separable 1-2-4-2-1 blur on a BGR raster stream
// Throughput: one word per cycle on each side while pix_stall / res_stall is low;
//   a pixel or drain word that makes a result passes s1 to s4 and the queue to res_*.
// Stream lag: the result of pixel (r, c) comes out with the pixel two rows
//   and two columns later; 2 + 2*width drain words flush the frame tail.
// Reset: positions, window and result queue clear at once; the four line
//   memories are not cleared and are only read where written this frame.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_blur_5x5 #(
	parameter int MAX_WIDTH = sbl_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// pixel / drain words in
	input  wire logic                          pix_valid,
	output logic                               pix_stall,
	input  wire logic                          action,
	input  wire logic [7:0]                    blue_in,
	input  wire logic [7:0]                    green_in,
	input  wire logic [7:0]                    red_in,
	// result words out
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [7:0]                         blue_out,
	output logic [7:0]                         green_out,
	output logic [7:0]                         red_out,
	output logic                               frame_end,
	// register writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sbl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sbl_pkg::DIM_W-1:0]     cfg_data
);
	import sbl_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);  // column index
	localparam int WW   = CW + 1;             // width value, up to MAX_WIDTH
	localparam int TR_W = DIM_W + 1;          // tick row runs to height + 1
	localparam logic [WW-1:0] RST_W =
		WW'((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH);
	localparam int CENTER_LINE = 1;           // line holding row r of the output

	// ------------------------------------------------------------------
	// Registers and positions
	// ------------------------------------------------------------------
	logic [WW-1:0]    w_q;
	logic [DIM_W-1:0] h_q;
	logic [DIM_W-1:0] in_row_q;   // row of the next pixel; == height while draining
	logic [CW-1:0]    in_col_q;
	logic [TR_W-1:0]  t_row_q;    // window centre of the next tick
	logic [CW-1:0]    t_col_q;

	logic             cfg_wr;
	logic             cfg_hit;
	logic [31:0]      cfg_val32;
	logic [WW-1:0]    w_next;
	logic [DIM_W-1:0] h_next;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_val32 = 32'(cfg_data);

	// out-of-range settings are clamped on the way in
	assign w_next = (cfg_val32 < MIN_DIM)   ? WW'(MIN_DIM)   :
	                (cfg_val32 > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
	assign h_next = (cfg_data < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : cfg_data;

	always_comb begin
		unique case (cfg_index)
			REG_FRAME_WIDTH:  cfg_hit = 1'b1;
			REG_FRAME_HEIGHT: cfg_hit = 1'b1;
			default:          cfg_hit = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// Accept stage: decide whether the word shifts the window and ticks
	// ------------------------------------------------------------------
	logic            acc;
	logic            tail;       // whole frame taken in, tail pending
	logic            pix_take;
	logic            tick;
	logic [WW-1:0]   w_m1;
	logic [TR_W-1:0] h_p1;
	logic [WW-1:0]   in_col_ext;
	logic [WW-1:0]   t_col_ext;
	logic            in_col_end;
	logic            t_col_end;
	ctrl_t           ctrl_s0;
	pix_t            shift_px;

	assign acc        = pix_valid && !pix_stall;
	assign tail       = (in_row_q >= h_q);
	assign pix_take   = acc && !action && !tail;
	// a pixel ticks once two of them are in; a drain word ticks on the tail
	assign tick       = (pix_take && ((in_col_q >= CW'(2)) || (in_row_q != '0)))
	                 || (acc && action && tail);

	assign w_m1       = w_q - 1'b1;
	assign h_p1       = TR_W'(h_q) + 1'b1;
	assign in_col_ext = WW'(in_col_q);
	assign t_col_ext  = WW'(t_col_q);
	assign in_col_end = (in_col_ext == w_m1);
	assign t_col_end  = (t_col_ext == w_m1);

	assign ctrl_s0.make      = (t_row_q >= TR_W'(2));
	assign ctrl_s0.hc        = (t_col_q >= CW'(2)) && ((t_col_ext + WW'(2)) < w_q);
	assign ctrl_s0.row_valid = (t_row_q < TR_W'(h_q));
	assign ctrl_s0.vblur     = (t_row_q >= TR_W'(4)) && (t_row_q < TR_W'(h_q));
	assign ctrl_s0.last      = (t_row_q == h_p1) && t_col_end;

	// drain words push zero into the window
	assign shift_px = action ? pix_t'('0) : pix_t'({red_in, green_in, blue_in});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= RST_W;
			h_q      <= DIM_W'(RESET_HEIGHT);
			in_row_q <= '0;
			in_col_q <= '0;
			t_row_q  <= '0;
			t_col_q  <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				w_q <= w_next;
			end
			if (cfg_index == REG_FRAME_HEIGHT) begin
				h_q <= h_next;
			end
			// any register write restarts the frame
			if (cfg_hit) begin
				in_row_q <= '0;
				in_col_q <= '0;
				t_row_q  <= '0;
				t_col_q  <= '0;
			end
		end else begin
			if (pix_take) begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (tick) begin
				if (ctrl_s0.last) begin
					// frame fully delivered: start over
					in_row_q <= '0;
					in_col_q <= '0;
					t_row_q  <= '0;
					t_col_q  <= '0;
				end else if (t_col_end) begin
					t_col_q <= '0;
					t_row_q <= t_row_q + 1'b1;
				end else begin
					t_col_q <= t_col_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Horizontal window: chain of five tap cells, newest pixel on the right
	// ------------------------------------------------------------------
	pix_t win      [TAPS];
	pix_t px_feed  [TAPS];
	sum_t hchain   [TAPS+1];

	assign hchain[0] = SUM_ZERO;

	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		if (k == TAPS - 1) begin : g_head
			assign px_feed[k] = shift_px;
		end else begin : g_body
			assign px_feed[k] = win[k+1];
		end

		sbl_tap_cell u_tap (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (pix_take || (tick && action)),
			.px_in    (px_feed[k]),
			.weight   (TAP_WEIGHT[k]),
			.psum_in  (hchain[k]),
			.px_out   (win[k]),
			.psum_out (hchain[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Pipeline: s1 window sum, s2 divide, s3 vertical sum + line write,
	// s4 divide and queue
	// ------------------------------------------------------------------
	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	ctrl_t         ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic [CW-1:0] col_s1, col_s2, col_s3;
	sum_t          hsum_s2;
	pix_t          center_s2;
	pix_t          hres;
	pix_t          hres_s3;
	sum_t          vsum_s4;
	pix_t          pass_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= tick;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1   <= ctrl_s0;
		col_s1    <= t_col_q;
		ctrl_s2   <= ctrl_s1;
		col_s2    <= col_s1;
		hsum_s2   <= hchain[TAPS];
		center_s2 <= win[TAPS/2];
		ctrl_s3   <= ctrl_s2;
		col_s3    <= col_s2;
		hres_s3   <= hres;
		ctrl_s4   <= ctrl_s3;
	end

	// outer columns keep the source; rows past the frame feed zero
	always_comb begin
		if (!ctrl_s2.row_valid) begin
			hres = '0;
		end else if (ctrl_s2.hc) begin
			hres = sum_div10(hsum_s2);
		end else begin
			hres = center_s2;
		end
	end

	// ------------------------------------------------------------------
	// Vertical pass: chain of line cells. Line k holds row pr-1-k of the
	// same column; each tick moves every line one step down the chain.
	// ------------------------------------------------------------------
	pix_t line_rd [LINES];
	pix_t line_wr [LINES];
	sum_t vchain  [LINES+1];

	assign vchain[0] = sum_add(SUM_ZERO, hres_s3, TAP_WEIGHT[TAPS-1]);

	for (genvar k = 0; k < LINES; k++) begin : g_line
		if (k == 0) begin : g_first
			assign line_wr[k] = hres_s3;
		end else begin : g_next
			assign line_wr[k] = line_rd[k-1];
		end

		sbl_line_cell #(
			.MAX_WIDTH (MAX_WIDTH)
		) u_line (
			.clk      (clk),
			.rd_col   (t_col_q),
			.wr_en    (valid_s3),
			.wr_col   (col_s3),
			.wr_data  (line_wr[k]),
			.weight   (TAP_WEIGHT[TAPS-2-k]),
			.psum_in  (vchain[k]),
			.rd_data  (line_rd[k]),
			.psum_out (vchain[k+1])
		);
	end

	always_ff @(posedge clk) begin
		vsum_s4 <= vchain[LINES];
		pass_s4 <= line_rd[CENTER_LINE];
	end

	// ------------------------------------------------------------------
	// Result queue and credit
	// ------------------------------------------------------------------
	pix_t       vres;
	res_t       res_word;
	res_t       head;
	fifo_stat_t fifo_stat;
	logic       fifo_push;
	logic       res_pop;
	logic [2:0] inflight;
	logic [FIFO_AW+1:0] credit_used;

	assign vres = ctrl_s4.vblur ? sum_div10(vsum_s4) : pass_s4;

	assign res_word.blue      = vres.blue;
	assign res_word.green     = vres.green;
	assign res_word.red       = vres.red;
	assign res_word.frame_end = ctrl_s4.last;

	assign fifo_push = valid_s4 && ctrl_s4.make;
	assign res_pop   = res_valid && !res_stall;

	sbl_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (res_word),
		.pop       (res_pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	// every result still in the pipe has a queue slot reserved
	assign inflight = 3'(valid_s1 && ctrl_s1.make) + 3'(valid_s2 && ctrl_s2.make)
	                + 3'(valid_s3 && ctrl_s3.make) + 3'(valid_s4 && ctrl_s4.make);
	assign credit_used = (FIFO_AW+2)'(fifo_stat.count) + (FIFO_AW+2)'(inflight);
	assign pix_stall   = (credit_used >= (FIFO_AW+2)'(FIFO_DEPTH));

	assign res_valid = fifo_stat.not_empty;
	assign blue_out  = head.blue;
	assign green_out = head.green;
	assign red_out   = head.red;
	assign frame_end = head.frame_end;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_tick_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		t_row_q <= h_p1)
		else $error("tick row ran past the frame tail");

	a_in_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= h_q)
		else $error("input row ran past the frame height");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && ctrl_s0.last) |=> (t_row_q == '0 && in_row_q == '0 && in_col_q == '0))
		else $error("positions not restarted after the last result");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> ((fifo_stat.count < FIFO_DEPTH) || res_pop))
		else $error("result pushed into a full queue");

endmodule

`default_nettype wire

// ===== design/sbl_tap_cell.sv =====
// ----------------------------------------------------------------------------
// sbl_tap_cell - one pixel of the horizontal window
// Holds a pixel, hands it to its left neighbour on each shift and adds its
// weighted channels to the running sum passed along the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_tap_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    shift_en,
	input  wire sbl_pkg::pix_t           px_in,
	input  wire logic [sbl_pkg::WT_W-1:0] weight,
	input  wire sbl_pkg::sum_t           psum_in,
	output sbl_pkg::pix_t                px_out,
	output sbl_pkg::sum_t                psum_out
);
	import sbl_pkg::*;

	pix_t px_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
		end else if (shift_en) begin
			px_q <= px_in;
		end
	end

	assign px_out   = px_q;
	assign psum_out = sum_add(psum_in, px_q, weight);

endmodule

`default_nettype wire

// ===== design/sbl_line_cell.sv =====
// ----------------------------------------------------------------------------
// sbl_line_cell - one line of horizontal results
// A line memory indexed by column. Read data is registered and carried to
// the write stage, where it feeds the next line and the vertical sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_line_cell #(
	parameter int MAX_WIDTH = sbl_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_col,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_col,
	input  wire sbl_pkg::pix_t                wr_data,
	input  wire logic [sbl_pkg::WT_W-1:0]     weight,
	input  wire sbl_pkg::sum_t                psum_in,
	output sbl_pkg::pix_t                     rd_data,
	output sbl_pkg::sum_t                     psum_out
);
	import sbl_pkg::*;

	pix_t mem [MAX_WIDTH];
	pix_t rd_s1;
	pix_t rd_s2;
	pix_t rd_s3;

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_col];
		if (wr_en) begin
			mem[wr_col] <= wr_data;
		end
	end

	// line data rides along with the tick to the write stage
	always_ff @(posedge clk) begin
		rd_s2 <= rd_s1;
		rd_s3 <= rd_s2;
	end

	assign rd_data  = rd_s3;
	assign psum_out = sum_add(psum_in, rd_s3, weight);

endmodule

`default_nettype wire

// ===== design/sbl_res_fifo.sv =====
// ----------------------------------------------------------------------------
// sbl_res_fifo - result queue in front of the output port
// Small register FIFO; the top level keeps enough credit that it never
// overflows.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_res_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sbl_pkg::res_t push_data,
	input  wire logic          pop,
	output sbl_pkg::res_t      head,
	output sbl_pkg::fifo_stat_t stat
);
	import sbl_pkg::*;

	res_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head           = mem[rd_ptr_q];
	assign stat.count     = count_q;
	assign stat.not_empty = (count_q != '0);

endmodule

`default_nettype wire

// ===== tb/tb_separable_blur_5x5.sv =====
// ----------------------------------------------------------------------------
// tb_separable_blur_5x5 - self-checking bench for the 5x5 separable blur
// Frames of BGR pixel words and drain words go in through a gapped driver.
// A behavioural model of both blur passes predicts every result word, and
// the monitor compares each field as results leave under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_separable_blur_5x5;

	localparam int TAPS        = sbl_pkg::TAPS;
	localparam int MAX_W       = sbl_pkg::DEF_MAX_WIDTH;
	localparam int BLUR_DIV    = 10;
	localparam int LATENCY     = 4;         // acceptance to result, from the top level
	localparam int LONG_HOLD   = 400;       // cycles of the one long receiver hold-off
	localparam int RAND_WORDS  = 560;       // live words in the random part
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int REPORT_CAP  = 40;

	// 1-2-4-2-1 taps; symmetric, so the packing order does not matter
	localparam logic [TAPS-1:0][2:0] BLUR_WT = {3'd1, 3'd2, 3'd4, 3'd2, 3'd1};

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// indexes that hold no register; a write there changes nothing
	localparam logic [sbl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [sbl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic          action;
		sbl_pkg::pix_t px;
	} in_word_t;

	// ------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------
	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          pix_valid = 1'b0;
	logic                          pix_stall;
	logic                          action    = 1'b0;
	logic [7:0]                    blue_in   = 8'h00;
	logic [7:0]                    green_in  = 8'h00;
	logic [7:0]                    red_in    = 8'h00;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [7:0]                    blue_out;
	logic [7:0]                    green_out;
	logic [7:0]                    red_out;
	logic                          frame_end;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [sbl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sbl_pkg::DIM_W-1:0]     cfg_data  = '0;

	separable_blur_5x5 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.action    (action),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// bench bookkeeping
	// ------------------------------------------------------------------
	in_word_t        word_q [$];   // words waiting for the driver
	sbl_pkg::res_t   blur_q [$];   // predicted result words, oldest first
	in_word_t        cur_word;
	sbl_pkg::res_t   want_word;
	int              words_queued    = 0;
	int              words_taken     = 0;
	int              live_words      = 0;
	int              frames_sent     = 0;
	int              reg_writes      = 0;
	int              results_checked = 0;
	int              err_count       = 0;
	int              cycle_count     = 0;
	int              gap_left        = 0;
	int              stall_left      = 0;
	int              hold_left       = 0;
	bit              idle_on         = 1'b1;
	bit              long_hold       = 1'b0;

	// ------------------------------------------------------------------
	// blur predictor: its own copy of registers, positions, window and
	// the four rows of horizontal results
	// ------------------------------------------------------------------
	sbl_pkg::pix_t              hrow_mem [0:4*MAX_W-1];
	sbl_pkg::pix_t [TAPS-1:0]   tap_win;      // [TAPS-1] is the newest pixel
	logic [11:0]                in_col, in_row, out_col, out_row;
	logic [sbl_pkg::DIM_W-1:0]  fw_reg, fh_reg;

	function automatic int width_now();
		int w;
		w = int'(fw_reg);
		if (w < sbl_pkg::MIN_DIM) w = sbl_pkg::MIN_DIM;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int height_now();
		int h;
		h = int'(fh_reg);
		if (h < sbl_pkg::MIN_DIM) h = sbl_pkg::MIN_DIM;
		return h;
	endfunction

	function automatic int mem_at(input int row, input int col);
		return (row % 4) * MAX_W + (col % MAX_W);
	endfunction

	function automatic sbl_pkg::pix_t blur_five(input sbl_pkg::pix_t [TAPS-1:0] p);
		int unsigned   sb, sg, sr;
		sbl_pkg::pix_t q;
		sb = 0;
		sg = 0;
		sr = 0;
		for (int k = 0; k < TAPS; k++) begin
			sb += int'(p[k].blue)  * int'(BLUR_WT[k]);
			sg += int'(p[k].green) * int'(BLUR_WT[k]);
			sr += int'(p[k].red)   * int'(BLUR_WT[k]);
		end
		q.blue  = 8'(sb / BLUR_DIV);
		q.green = 8'(sg / BLUR_DIV);
		q.red   = 8'(sr / BLUR_DIV);
		return q;
	endfunction

	function automatic void blur_reset();
		for (int i = 0; i < 4*MAX_W; i++)
			hrow_mem[i] = '0;
		tap_win = '0;
		in_col  = '0;
		in_row  = '0;
		out_col = '0;
		out_row = '0;
		fw_reg  = sbl_pkg::DIM_W'(sbl_pkg::RESET_WIDTH);
		fh_reg  = sbl_pkg::DIM_W'(sbl_pkg::RESET_HEIGHT);
	endfunction

	function automatic void blur_config(input logic [sbl_pkg::CFG_IDX_W-1:0] idx,
			input logic [sbl_pkg::DIM_W-1:0] val);
		if (idx == sbl_pkg::REG_FRAME_WIDTH)
			fw_reg = val;
		else if (idx == sbl_pkg::REG_FRAME_HEIGHT)
			fh_reg = val;
		else
			return;
		// any real register write restarts the frame
		in_col  = '0;
		in_row  = '0;
		out_col = '0;
		out_row = '0;
	endfunction

	function automatic void shift_win(input sbl_pkg::pix_t px);
		for (int k = 0; k < TAPS-1; k++)
			tap_win[k] = tap_win[k+1];
		tap_win[TAPS-1] = px;
	endfunction

	// one pipeline step centred on pixel (pr, pc)
	function automatic void blur_tick(input int pr, input int pc);
		int                        w, h, r;
		sbl_pkg::pix_t             hres, v;
		sbl_pkg::pix_t [TAPS-1:0]  col;
		sbl_pkg::res_t             e;
		w = width_now();
		h = height_now();
		hres = '0;
		// horizontal pass: two outer columns each side keep the source value
		if (pr < h)
			hres = (pc >= 2 && pc + 2 < w) ? blur_five(tap_win) : tap_win[2];
		if (pr >= 2) begin
			r = pr - 2;
			// vertical pass: two outer rows each side keep the horizontal result
			if (r >= 2 && r + 2 < h) begin
				col[0] = hrow_mem[mem_at(r - 2, pc)];
				col[1] = hrow_mem[mem_at(r - 1, pc)];
				col[2] = hrow_mem[mem_at(r, pc)];
				col[3] = hrow_mem[mem_at(r + 1, pc)];
				col[4] = hres;
				v = blur_five(col);
			end else begin
				v = hrow_mem[mem_at(r, pc)];
			end
			e.blue      = v.blue;
			e.green     = v.green;
			e.red       = v.red;
			e.frame_end = (r == h - 1 && pc == w - 1);
			blur_q.push_back(e);
			out_col = out_col + 12'd1;
			if (int'(out_col) >= w) begin
				out_col = '0;
				out_row = out_row + 12'd1;
				// last result of the frame: both positions go back to the start
				if (int'(out_row) >= h) begin
					out_row = '0;
					in_row  = '0;
					in_col  = '0;
				end
			end
		end
		if (pr < h)
			hrow_mem[mem_at(pr, pc)] = hres;
	endfunction

	function automatic void blur_step(input in_word_t wd);
		int w, h;
		w = width_now();
		h = height_now();
		if (wd.action == ACT_PIXEL) begin
			// pixel while the tail waits to be drained: ignored
			if (int'(in_row) >= h)
				return;
			shift_win(wd.px);
			if (in_col >= 12'd2)
				blur_tick(int'(in_row), int'(in_col) - 2);
			else if (in_row > 12'd0)
				blur_tick(int'(in_row) - 1, int'(in_col) + w - 2);
			in_col = in_col + 12'd1;
			if (int'(in_col) >= w) begin
				in_col = '0;
				in_row = in_row + 12'd1;
			end
		end else begin
			// drain with nothing pending: no effect
			if (int'(in_row) < h)
				return;
			shift_win('0);
			blur_tick(int'(out_row) + 2, int'(out_col));
		end
	endfunction

	// ------------------------------------------------------------------
	// random helpers
	// ------------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_chan();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic sbl_pkg::pix_t rand_px();
		sbl_pkg::pix_t p;
		p.blue  = rand_chan();
		p.green = rand_chan();
		p.red   = rand_chan();
		return p;
	endfunction

	function automatic logic [11:0] pick_width();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 12'($urandom_range(0, 4));    // below range, saturates
		if (r < 4)  return 12'($urandom_range(13, 40));
		return 12'($urandom_range(5, 12));
	endfunction

	function automatic logic [11:0] pick_height();
		if ($urandom_range(0, 19) == 0)
			return 12'($urandom_range(0, 4));
		return 12'($urandom_range(5, 8));
	endfunction

	// ------------------------------------------------------------------
	// stimulus tasks
	// ------------------------------------------------------------------
	task automatic push_word(input logic act, input sbl_pkg::pix_t px);
		in_word_t wd;
		wd.action = act;
		wd.px     = px;
		word_q.push_back(wd);
		words_queued++;
	endtask

	// one frame of pixels and its drain tail; noisy frames carry words the
	// block must ignore, cut >= 0 stops after that many pixels
	task automatic send_frame(input int w, input int h, input bit noisy, input int cut);
		for (int i = 0; i < w*h; i++) begin
			if (cut >= 0 && i >= cut)
				return;
			if (noisy && $urandom_range(0, 19) == 0)
				push_word(ACT_DRAIN, rand_px());
			push_word(ACT_PIXEL, rand_px());
			live_words++;
		end
		for (int i = 0; i < 2 + 2*w; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				push_word(ACT_PIXEL, rand_px());
			push_word(ACT_DRAIN, rand_px());
			live_words++;
		end
		if (noisy && $urandom_range(0, 3) == 0)
			push_word(ACT_DRAIN, rand_px());
		frames_sent++;
	endtask

	// sender holds back until every word is in and every result is out,
	// then lets the pipeline run dry of words that made no result
	task automatic wait_settled();
		while (words_taken != words_queued || blur_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sbl_pkg::CFG_IDX_W-1:0] idx,
			input logic [sbl_pkg::DIM_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		blur_config(idx, val);
		reg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(input string msg);
		if (err_count < REPORT_CAP)
			$display("MISMATCH @%0d: %s", cycle_count, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
				results_checked, name, got, want));
	endtask

	// ------------------------------------------------------------------
	// driver: presents queued words; predicts each one as it is accepted
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			action    <= ACT_PIXEL;
			blue_in   <= 8'h00;
			green_in  <= 8'h00;
			red_in    <= 8'h00;
			gap_left   = 0;
		end else begin
			if (pix_valid && !pix_stall) begin
				blur_step(cur_word);
				words_taken++;
				gap_left = idle_on ? pick_gap() : 0;
			end
			// a stalled word stays on the bus unchanged
			if (!pix_valid || !pix_stall) begin
				if (gap_left == 0 && word_q.size() != 0) begin
					cur_word   = word_q.pop_front();
					pix_valid <= 1'b1;
					action    <= cur_word.action;
					blue_in   <= cur_word.px.blue;
					green_in  <= cur_word.px.green;
					red_in    <= cur_word.px.red;
				end else begin
					if (gap_left != 0)
						gap_left--;
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver back-pressure; the long hold-off is counted here
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (long_hold) begin
				long_hold = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				stall_left = idle_on ? pick_gap() : 0;
				if (stall_left != 0) begin
					stall_left--;
					res_stall <= 1'b1;
				end else begin
					res_stall <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: every accepted result against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
			if (blur_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected (b=%0d g=%0d r=%0d)",
					blue_out, green_out, red_out));
			end else begin
				want_word = blur_q.pop_front();
				check_field("blue_out",  blue_out,  want_word.blue);
				check_field("green_out", green_out, want_word.green);
				check_field("red_out",   red_out,   want_word.red);
				check_field("frame_end", 8'(frame_end), 8'(want_word.frame_end));
			end
			results_checked++;
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still expected",
			cycle_count, blur_q.size());
		$display("tb_separable_blur_5x5: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		sbl_pkg::pix_t              px;
		logic [sbl_pkg::DIM_W-1:0]  wv, hv;
		int                         phase, choice, nfr, fw, fh, cut;
		blur_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: minimum 5x5 frame, both sizes written below range
		write_reg(sbl_pkg::REG_FRAME_WIDTH,  12'd3);
		write_reg(sbl_pkg::REG_FRAME_HEIGHT, 12'd1);
		push_word(ACT_DRAIN, '0);                      // nothing pending yet
		for (int k = 0; k < 25; k++) begin
			if (k == 0 || k == 24) begin
				px = '1;
			end else begin
				px.blue  = (k % 2 != 0) ? 8'hFF : 8'h00;
				px.green = (k % 3 == 0) ? 8'hFF : 8'h00;
				px.red   = 8'(k * 37);
			end
			if (k == 7)
				push_word(ACT_DRAIN, '1);              // drain mid-frame, ignored
			push_word(ACT_PIXEL, px);
		end
		push_word(ACT_PIXEL, '1);                      // pixel while tail pending, ignored
		repeat (12) push_word(ACT_DRAIN, '0);          // 2 + 2*width drains end the frame
		push_word(ACT_DRAIN, '1);                      // frame done, nothing pending
		frames_sent++;
		wait_settled();

		// random part: mostly whole frames back to back, some noisy, some cut
		phase = 0;
		live_words = 0;
		while (live_words < RAND_WORDS || phase <= 2) begin
			idle_on = ($urandom_range(0, 3) != 0);
			choice  = $urandom_range(0, 3);
			wv      = pick_width();
			hv      = pick_height();
			if (phase == 2) begin
				// big enough to back the block up behind the long hold-off
				wv      = 12'd16;
				hv      = 12'd6;
				choice  = 3;
				idle_on = 1'b1;
			end
			if (phase == 0 || choice >= 2) begin
				write_reg(sbl_pkg::REG_FRAME_WIDTH,  wv);
				write_reg(sbl_pkg::REG_FRAME_HEIGHT, hv);
			end else if (choice == 0) begin
				write_reg(sbl_pkg::REG_FRAME_WIDTH, wv);
			end else begin
				write_reg(sbl_pkg::REG_FRAME_HEIGHT, hv);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
					12'($urandom_range(0, 4095)));
			fw  = width_now();
			fh  = height_now();
			nfr = $urandom_range(1, 3);
			if (phase == 2)
				long_hold = 1'b1;
			for (int f = 0; f < nfr; f++) begin
				cut = -1;
				if (f == nfr - 1 && $urandom_range(0, 4) == 0)
					cut = $urandom_range(1, fw*fh - 1);
				send_frame(fw, fh, $urandom_range(0, 2) == 0, cut);
			end
			wait_settled();
			phase++;
		end

		// size extremes as short cut frames, run without idling
		idle_on = 1'b0;
		write_reg(sbl_pkg::REG_FRAME_WIDTH,  12'hFFF);  // saturates to the widest row
		write_reg(sbl_pkg::REG_FRAME_HEIGHT, 12'd5);
		send_frame(width_now(), height_now(), 1'b0, 60);
		wait_settled();
		write_reg(sbl_pkg::REG_FRAME_WIDTH,  12'd0);
		write_reg(sbl_pkg::REG_FRAME_HEIGHT, 12'hFFF);
		send_frame(width_now(), height_now(), 1'b0, 60);
		wait_settled();

		// exact widest row, a short cut frame
		idle_on = 1'b1;
		write_reg(sbl_pkg::REG_FRAME_WIDTH,  12'd2048);
		write_reg(sbl_pkg::REG_FRAME_HEIGHT, 12'd4);
		send_frame(width_now(), height_now(), 1'b1, 40);
		wait_settled();

		// a small frame after the cut one: the write must restart cleanly
		write_reg(sbl_pkg::REG_FRAME_WIDTH,  12'd5);
		write_reg(sbl_pkg::REG_FRAME_HEIGHT, 12'd5);
		send_frame(5, 5, 1'b1, -1);
		wait_settled();

		$display("covered %0d whole frames plus cut ones, sizes 5x5 up to 2048 wide and 4095 tall, %0d words, %0d reg writes",
			frames_sent, words_taken, reg_writes);
		$display("checked %0d result words in %0d cycles, %0d mismatches",
			results_checked, cycle_count, err_count);
		if (err_count == 0)
			$display("tb_separable_blur_5x5: PASS");
		else
			$display("tb_separable_blur_5x5: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
